// ===== design/tdfl_pkg.sv =====
package tdfl_pkg;

  localparam int DEF_TABLE_DEPTH = 32;
  localparam int DEF_STATE_BITS  = 16;
  localparam int DEF_EVENT_BITS  = 8;

  localparam int INDEX_W  = 5;
  localparam int STATE_W  = 16;
  localparam int EVENT_W  = 8;
  localparam int ACTION_W = 8;

  typedef enum logic {
    KIND_WRITE  = 1'b0,
    KIND_LOOKUP = 1'b1
  } kind_t;

  // One item as it travels down the chain, with its partial result.
  typedef struct packed {
    kind_t                kind;
    logic [INDEX_W-1:0]   entry_index;
    logic [STATE_W-1:0]   entry_state_mask;
    logic [EVENT_W-1:0]   entry_event;
    logic [STATE_W-1:0]   entry_new_state;
    logic [ACTION_W-1:0]  entry_action;
    logic [STATE_W-1:0]   current_state;
    logic [EVENT_W-1:0]   event_code;
    logic                 done;
    logic                 matched;
    logic [ACTION_W-1:0]  action_code;
    logic [STATE_W-1:0]   next_state;
  } item_t;

endpackage

// ===== design/table_driven_fsm_lookup.sv =====
// Programmable state-machine transition lookup.
//
// Input channel (in_*): one item per accepted valid/stall handshake. A write
// item (in_kind = 0) stores one table entry at in_entry_index; indexes past
// the table are dropped. A lookup item (in_kind = 1) searches the entries in
// index order, stopping at the first zero mask, for the first entry whose
// mask overlaps in_current_state and whose event equals in_event_code.
// Result channel (out_*): exactly one item per input item, in order. Writes
// return all zeros; a lookup returns matched, the action and the next state
// (the current state when no match or when the entry's new state is zero).
// Each table entry lives in one cell of a chain; items march one cell per
// cycle unless held, so a lookup sees exactly the writes accepted ahead of it.
// An item passes every cell register, then the output register, to out_valid.
// Throughput: one item per cycle unless held, set by the single-stage cell hop.
// Reset clears every entry mask (empty table) and all valid flags at once.
// When the receiver stalls with a result waiting, the chain keeps moving as
// long as its last cell is empty; otherwise it holds and in_stall rises.
module table_driven_fsm_lookup #(
  parameter int TABLE_DEPTH = tdfl_pkg::DEF_TABLE_DEPTH,
  parameter int STATE_BITS  = tdfl_pkg::DEF_STATE_BITS,
  parameter int EVENT_BITS  = tdfl_pkg::DEF_EVENT_BITS
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_kind,
  input  logic [tdfl_pkg::INDEX_W-1:0]      in_entry_index,
  input  logic [tdfl_pkg::STATE_W-1:0]      in_entry_state_mask,
  input  logic [tdfl_pkg::EVENT_W-1:0]      in_entry_event,
  input  logic [tdfl_pkg::STATE_W-1:0]      in_entry_new_state,
  input  logic [tdfl_pkg::ACTION_W-1:0]     in_entry_action,
  input  logic [tdfl_pkg::STATE_W-1:0]      in_current_state,
  input  logic [tdfl_pkg::EVENT_W-1:0]      in_event_code,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_matched,
  output logic [tdfl_pkg::ACTION_W-1:0]     out_action_code,
  output logic [tdfl_pkg::STATE_W-1:0]      out_next_state
);

  // Keep only the state and event bits the engine is built for.
  localparam logic [tdfl_pkg::STATE_W-1:0] STATE_LIM =
    (STATE_BITS >= tdfl_pkg::STATE_W) ? '1 :
    tdfl_pkg::STATE_W'((32'd1 << STATE_BITS) - 32'd1);
  localparam logic [tdfl_pkg::EVENT_W-1:0] EVENT_LIM =
    (EVENT_BITS >= tdfl_pkg::EVENT_W) ? '1 :
    tdfl_pkg::EVENT_W'((32'd1 << EVENT_BITS) - 32'd1);

  logic                   chain_valid [0:TABLE_DEPTH];
  tdfl_pkg::item_t        chain_item  [0:TABLE_DEPTH];
  tdfl_pkg::item_t        head_item;
  logic                   advance;

  logic                              out_valid_r;
  logic                              out_matched_r;
  logic [tdfl_pkg::ACTION_W-1:0]     out_action_r;
  logic [tdfl_pkg::STATE_W-1:0]      out_next_state_r;

  // Hold the whole chain only when a finished item would land on a
  // stalled, still-occupied output register.
  assign advance  = !(out_valid_r && out_stall && chain_valid[TABLE_DEPTH]);
  assign in_stall = !advance;

  // Build the entering item; a lookup starts out unmatched with its own state.
  always_comb begin
    head_item.kind             = tdfl_pkg::kind_t'(in_kind);
    head_item.entry_index      = in_entry_index;
    head_item.entry_state_mask = in_entry_state_mask & STATE_LIM;
    head_item.entry_event      = in_entry_event & EVENT_LIM;
    head_item.entry_new_state  = in_entry_new_state & STATE_LIM;
    head_item.entry_action     = in_entry_action;
    head_item.current_state    = in_current_state & STATE_LIM;
    head_item.event_code       = in_event_code & EVENT_LIM;
    head_item.done             = 1'b0;
    head_item.matched          = 1'b0;
    head_item.action_code      = '0;
    head_item.next_state       = (in_kind == tdfl_pkg::KIND_LOOKUP) ?
                                 (in_current_state & STATE_LIM) : '0;
  end

  assign chain_valid[0] = in_valid;
  assign chain_item[0]  = head_item;

  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    tdfl_cell #(
      .CELL_IDX (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .valid_i (chain_valid[k]),
      .item_i  (chain_item[k]),
      .valid_o (chain_valid[k+1]),
      .item_o  (chain_item[k+1])
    );
  end

  // Output register: load a finished item, drop a delivered one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && chain_valid[TABLE_DEPTH]) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && chain_valid[TABLE_DEPTH]) begin
      out_matched_r    <= chain_item[TABLE_DEPTH].matched;
      out_action_r     <= chain_item[TABLE_DEPTH].action_code;
      out_next_state_r <= chain_item[TABLE_DEPTH].next_state;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_matched     = out_matched_r;
  assign out_action_code = out_action_r;
  assign out_next_state  = out_next_state_r;

endmodule

// ===== design/tdfl_cell.sv =====
module tdfl_cell #(
  parameter int CELL_IDX = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           advance,
  input  logic           valid_i,
  input  tdfl_pkg::item_t item_i,
  output logic           valid_o,
  output tdfl_pkg::item_t item_o
);

  logic                              valid_r;
  tdfl_pkg::item_t                   item_r;
  tdfl_pkg::item_t                   item_nxt;
  logic [tdfl_pkg::STATE_W-1:0]      mask_r;
  logic [tdfl_pkg::EVENT_W-1:0]      event_r;
  logic [tdfl_pkg::STATE_W-1:0]      dest_state_r;
  logic [tdfl_pkg::ACTION_W-1:0]     action_r;
  logic                              wr_en;

  assign wr_en = valid_i && advance && (item_i.kind == tdfl_pkg::KIND_WRITE) &&
                 (int'(item_i.entry_index) == CELL_IDX);

  // Resolve the lookup at this entry unless an earlier cell already did.
  always_comb begin
    item_nxt = item_i;
    if (item_i.kind == tdfl_pkg::KIND_LOOKUP && !item_i.done) begin
      if (mask_r == '0) begin
        item_nxt.done = 1'b1;
      end else if (((mask_r & item_i.current_state) != '0) &&
                   (event_r == item_i.event_code)) begin
        item_nxt.done        = 1'b1;
        item_nxt.matched     = 1'b1;
        item_nxt.action_code = action_r;
        if (dest_state_r != '0) begin
          item_nxt.next_state = dest_state_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      mask_r  <= '0;
    end else begin
      if (advance) begin
        valid_r <= valid_i;
      end
      if (wr_en) begin
        mask_r <= item_i.entry_state_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item_r <= item_nxt;
    end
    if (wr_en) begin
      event_r      <= item_i.entry_event;
      dest_state_r <= item_i.entry_new_state;
      action_r     <= item_i.entry_action;
    end
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;

endmodule

// ===== design/tdfl_checker.sv =====
module tdfl_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_stall,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic                              out_matched,
  input logic [tdfl_pkg::ACTION_W-1:0]     out_action_code,
  input logic [tdfl_pkg::STATE_W-1:0]      out_next_state
);

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_matched) &&
      $stable(out_action_code) && $stable(out_next_state))
    else $error("stalled result changed");

  // Input backs up only behind a stalled result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // A match needs an overlapping state, so the next state is never zero.
  a_match_state: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_matched |-> out_next_state != '0)
    else $error("matched result with zero next state");

  a_nomatch_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_matched |-> out_action_code == '0)
    else $error("action code without a match");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind table_driven_fsm_lookup tdfl_checker u_tdfl_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_matched     (out_matched),
  .out_action_code (out_action_code),
  .out_next_state  (out_next_state)
);

// ===== dv/tb_table_driven_fsm_lookup.sv =====
`timescale 1ns / 1ps

module tb_table_driven_fsm_lookup;

  localparam int TBL_DEPTH   = tdfl_pkg::DEF_TABLE_DEPTH;
  localparam int PHASE_ITEMS = 450;
  localparam int IDX_W       = tdfl_pkg::INDEX_W;
  localparam int ST_W        = tdfl_pkg::STATE_W;
  localparam int EV_W        = tdfl_pkg::EVENT_W;
  localparam int ACT_W       = tdfl_pkg::ACTION_W;

  // One input item as the driver builds it.
  typedef struct {
    tdfl_pkg::kind_t  kind;
    logic [IDX_W-1:0] idx;
    logic [ST_W-1:0]  mask;
    logic [EV_W-1:0]  ev;
    logic [ST_W-1:0]  dest_state;
    logic [ACT_W-1:0] action;
    logic [ST_W-1:0]  cur_state;
    logic [EV_W-1:0]  ev_code;
  } fsm_req_t;

  // One result item.
  typedef struct {
    logic             matched;
    logic [ACT_W-1:0] action;
    logic [ST_W-1:0]  next_state;
  } fsm_rsp_t;

  // One transition table slot.
  typedef struct {
    logic [ST_W-1:0]  mask;
    logic [EV_W-1:0]  ev;
    logic [ST_W-1:0]  dest_state;
    logic [ACT_W-1:0] action;
  } trans_entry_t;

  // Shadow transition table plus the queue of expected results for all items.
  class fsm_lookup_scoreboard;
    trans_entry_t trans_tbl[TBL_DEPTH];
    fsm_rsp_t     rsp_q[$];
    int unsigned  errors;

    function new();
      errors = 0;
      foreach (trans_tbl[k]) trans_tbl[k] = '{default: '0};
    endfunction

    function int pending();
      return rsp_q.size();
    endfunction

    function void flag(string msg);
      errors++;
      $display("%0t: %s", $time, msg);
    endfunction

    // Apply an accepted item to the shadow table and queue its result.
    function void note_item(fsm_req_t req);
      fsm_rsp_t rsp;
      rsp.matched    = 1'b0;
      rsp.action     = '0;
      rsp.next_state = '0;
      if (req.kind == tdfl_pkg::KIND_WRITE) begin
        if (int'(req.idx) < TBL_DEPTH) begin
          trans_tbl[req.idx].mask       = req.mask;
          trans_tbl[req.idx].ev         = req.ev;
          trans_tbl[req.idx].dest_state = req.dest_state;
          trans_tbl[req.idx].action     = req.action;
        end
      end else begin
        rsp.next_state = req.cur_state;
        for (int k = 0; k < TBL_DEPTH; k++) begin
          if (trans_tbl[k].mask == '0) break;
          if ((trans_tbl[k].mask & req.cur_state) != '0 && trans_tbl[k].ev == req.ev_code) begin
            rsp.matched = 1'b1;
            rsp.action  = trans_tbl[k].action;
            if (trans_tbl[k].dest_state != '0) rsp.next_state = trans_tbl[k].dest_state;
            break;
          end
        end
      end
      rsp_q.push_back(rsp);
    endfunction

    // Compare a result against the oldest expectation.
    function void check_result(fsm_rsp_t got);
      fsm_rsp_t want;
      if (rsp_q.size() == 0) begin
        flag($sformatf("unexpected result: expected none, actual matched=%0b action=%h next=%h",
                       got.matched, got.action, got.next_state));
        return;
      end
      want = rsp_q.pop_front();
      if (got.matched !== want.matched)
        flag($sformatf("matched: expected %0b, actual %0b", want.matched, got.matched));
      if (got.action !== want.action)
        flag($sformatf("action_code: expected %h, actual %h", want.action, got.action));
      if (got.next_state !== want.next_state)
        flag($sformatf("next_state: expected %h, actual %h", want.next_state, got.next_state));
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_valid;
  logic             in_stall;
  logic             in_kind;
  logic [IDX_W-1:0] in_entry_index;
  logic [ST_W-1:0]  in_entry_state_mask;
  logic [EV_W-1:0]  in_entry_event;
  logic [ST_W-1:0]  in_entry_new_state;
  logic [ACT_W-1:0] in_entry_action;
  logic [ST_W-1:0]  in_current_state;
  logic [EV_W-1:0]  in_event_code;
  logic             out_valid;
  logic             out_stall;
  logic             out_matched;
  logic [ACT_W-1:0] out_action_code;
  logic [ST_W-1:0]  out_next_state;

  fsm_lookup_scoreboard sb;
  int unsigned          items_sent;
  int                   snd_idle_pct;
  int                   rcv_stall_pct;

  table_driven_fsm_lookup i_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_entry_index      (in_entry_index),
    .in_entry_state_mask (in_entry_state_mask),
    .in_entry_event      (in_entry_event),
    .in_entry_new_state  (in_entry_new_state),
    .in_entry_action     (in_entry_action),
    .in_current_state    (in_current_state),
    .in_event_code       (in_event_code),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_matched         (out_matched),
    .out_action_code     (out_action_code),
    .out_next_state      (out_next_state)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: stall at random, at the rate of the current phase.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
  end

  // Monitor both handshakes at the clock edge. Every testbench drive is
  // nonblocking, so the values seen here are the ones the block samples.
  always @(posedge clk) begin
    fsm_req_t acc;
    fsm_rsp_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        acc.kind       = tdfl_pkg::kind_t'(in_kind);
        acc.idx        = in_entry_index;
        acc.mask       = in_entry_state_mask;
        acc.ev         = in_entry_event;
        acc.dest_state = in_entry_new_state;
        acc.action     = in_entry_action;
        acc.cur_state  = in_current_state;
        acc.ev_code    = in_event_code;
        sb.note_item(acc);
      end
      if (out_valid && !out_stall) begin
        got.matched    = out_matched;
        got.action     = out_action_code;
        got.next_state = out_next_state;
        sb.check_result(got);
      end
    end
  end

  // Fill every field at random; callers then pin the ones that matter.
  function automatic fsm_req_t rand_req();
    fsm_req_t r;
    r.kind       = tdfl_pkg::kind_t'($urandom_range(0, 1));
    r.idx        = IDX_W'($urandom);
    r.mask       = ST_W'($urandom);
    r.ev         = EV_W'($urandom);
    r.dest_state = ST_W'($urandom);
    r.action     = ACT_W'($urandom);
    r.cur_state  = ST_W'($urandom);
    r.ev_code    = EV_W'($urandom);
    return r;
  endfunction

  // Present one item, with an optional random gap ahead of it, and hold it
  // until the block accepts it.
  task automatic send_item(input fsm_req_t req);
    if ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < snd_idle_pct);
    end
    in_valid            <= 1'b1;
    in_kind             <= req.kind;
    in_entry_index      <= req.idx;
    in_entry_state_mask <= req.mask;
    in_entry_event      <= req.ev;
    in_entry_new_state  <= req.dest_state;
    in_entry_action     <= req.action;
    in_current_state    <= req.cur_state;
    in_event_code       <= req.ev_code;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic write_entry(input logic [IDX_W-1:0] idx, input logic [ST_W-1:0] mask,
                             input logic [EV_W-1:0] ev, input logic [ST_W-1:0] dest_state,
                             input logic [ACT_W-1:0] action);
    fsm_req_t r;
    r            = rand_req();
    r.kind       = tdfl_pkg::KIND_WRITE;
    r.idx        = idx;
    r.mask       = mask;
    r.ev         = ev;
    r.dest_state = dest_state;
    r.action     = action;
    send_item(r);
  endtask

  task automatic lookup(input logic [ST_W-1:0] cur_state, input logic [EV_W-1:0] ev_code);
    fsm_req_t r;
    r           = rand_req();
    r.kind      = tdfl_pkg::KIND_LOOKUP;
    r.cur_state = cur_state;
    r.ev_code   = ev_code;
    send_item(r);
  endtask

  // Hold the sender until every outstanding result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // One phase of random traffic. Most of it programs a table prefix with a
  // small pool of events and then runs lookups that can hit it; the rest is
  // noise that rewrites random slots, often with a zero mask.
  task automatic run_phase(input int snd_pct, input int rcv_pct);
    int unsigned     stop_at;
    int              len;
    logic [EV_W-1:0] ev_pool[4];
    logic [EV_W-1:0] ev;
    logic [ST_W-1:0] m;
    fsm_req_t        r;
    snd_idle_pct  = snd_pct;
    rcv_stall_pct = rcv_pct;
    stop_at       = items_sent + PHASE_ITEMS;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) < 7) begin
        foreach (ev_pool[k]) ev_pool[k] = EV_W'($urandom);
        // Fill the whole table now and then, so the scan runs off the end.
        len = ($urandom_range(0, 7) == 0) ? TBL_DEPTH : $urandom_range(1, TBL_DEPTH - 1);
        for (int k = 0; k < len; k++) begin
          case ($urandom_range(0, 2))
            0:       m = ST_W'(1) << $urandom_range(0, ST_W - 1);
            1:       m = ST_W'($urandom) & ST_W'($urandom);
            default: m = ST_W'($urandom);
          endcase
          if (m == '0) m = ST_W'(1) << $urandom_range(0, ST_W - 1);
          write_entry(IDX_W'(k), m, ev_pool[$urandom_range(0, 3)],
                      ($urandom_range(0, 3) == 0) ? '0 : ST_W'($urandom),
                      ACT_W'($urandom));
        end
        // Usually close the prefix; otherwise leave stale entries behind it.
        if (len < TBL_DEPTH && $urandom_range(0, 3) != 0)
          write_entry(IDX_W'(len), '0, EV_W'($urandom), ST_W'($urandom),
                      ACT_W'($urandom));
        if ($urandom_range(0, 9) == 0) drain();
        repeat ($urandom_range(8, 24)) begin
          ev = ($urandom_range(0, 4) == 0) ? EV_W'($urandom) : ev_pool[$urandom_range(0, 3)];
          case ($urandom_range(0, 9))
            0:       lookup(ST_W'($urandom), ev);
            1:       lookup('0, ev);
            default: lookup(ST_W'(1) << $urandom_range(0, ST_W - 1), ev);
          endcase
        end
      end else begin
        repeat ($urandom_range(1, 8)) begin
          r = rand_req();
          if ($urandom_range(0, 3) == 0) r.mask = '0;
          send_item(r);
        end
      end
    end
    drain();
  endtask

  // Timeout guard.
  initial begin
    #2000000;
    $display("tb_table_driven_fsm_lookup: FAIL");
    $finish;
  end

  initial begin
    sb                  = new();
    items_sent          = 0;
    snd_idle_pct        = 0;
    rcv_stall_pct       = 0;
    rst_n               = 1'b0;
    in_valid            = 1'b0;
    in_kind             = tdfl_pkg::KIND_WRITE;
    in_entry_index      = '0;
    in_entry_state_mask = '0;
    in_entry_event      = '0;
    in_entry_new_state  = '0;
    in_entry_action     = '0;
    in_current_state    = '0;
    in_event_code       = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, then a short table with a zero-mask end marker.
    lookup(16'h8000, 8'hFF);                              // empty table: no match
    write_entry(5'd0, 16'hFFFF, 8'hFF, 16'h0000, 8'hFF);  // any state, keep state
    write_entry(5'd1, 16'h0001, 8'h00, 16'hFFFF, 8'h00);  // match with zero action
    write_entry(5'd31, 16'hFFFF, 8'h00, 16'h8000, 8'h5A); // hidden behind the end marker
    lookup(16'h0001, 8'hFF);                              // slot 0, next state held
    lookup(16'h0001, 8'h00);                              // slot 1, new state taken
    lookup(16'h8000, 8'h00);                              // scan stops at slot 2: no match
    lookup(16'h0000, 8'hFF);                              // zero state overlaps nothing
    lookup(16'hFFFF, 8'h00);                              // not one-hot: slot 1
    lookup(16'h0101, 8'h00);                              // two bits, slot 1 via bit 0
    write_entry(5'd0, 16'h0000, 8'hFF, 16'hFFFF, 8'hFF);  // zero mask empties the table
    lookup(16'h0001, 8'h00);                              // no match again
    write_entry(5'd0, 16'h8000, 8'h00, 16'h0001, 8'h80);
    lookup(16'h8000, 8'h00);                              // top state bit
    drain();

    // Random phases: sender rarely idle with a busy receiver, then the
    // reverse, then full throughput on both sides.
    run_phase(14, 78);
    run_phase(78, 14);
    run_phase(0, 0);

    // Let the pipeline run empty to catch any stray result.
    drain();
    repeat (TBL_DEPTH + 8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_table_driven_fsm_lookup: PASS");
    end else begin
      $display("tb_table_driven_fsm_lookup: FAIL");
    end
    $finish;
  end

endmodule
